>>> rtl/core/llx_pkg.sv
package llx_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int COORD_WIDTH = 32;
   localparam int DELTA_WIDTH = COORD_WIDTH + 1;
   localparam int DEN_WIDTH   = 2 * COORD_WIDTH;
   localparam int NUM_WIDTH   = 2 * COORD_WIDTH + 2;
   localparam int DIV_CELLS   = COORD_WIDTH;

   localparam logic [1:0] STATUS_HIT      = 2'd0;
   localparam logic [1:0] STATUS_MISS     = 2'd1;
   localparam logic [1:0] STATUS_SINGULAR = 2'd2;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DELTA_WIDTH-1:0] delta_type;

   typedef struct packed {
      coord_type a_origin_x;
      coord_type a_origin_y;
      coord_type a_origin_z;
      coord_type a_dir_x;
      coord_type a_dir_y;
      coord_type a_dir_z;
      coord_type b_origin_x;
      coord_type b_origin_y;
      coord_type b_origin_z;
      coord_type b_dir_x;
      coord_type b_dir_y;
      coord_type b_dir_z;
   } req_word_type;

   typedef struct packed {
      coord_type  line_param;
      logic [1:0] status;
      logic       clipped;
   } rsp_word_type;

   // Geometry that rides alongside the quotient bits.
   typedef struct packed {
      coord_type [2:0] ad;
      coord_type [2:0] bd;
      delta_type [2:0] v;
      logic            singular;
      logic            t_neg;
      logic            s_neg;
      logic            t_ovf;
      logic            s_ovf;
   } ctx_type;

   typedef struct packed {
      logic [DEN_WIDTH-1:0]   r;
      logic [COORD_WIDTH-1:0] nlo;
      logic [COORD_WIDTH-1:0] q;
   } lane_type;

   typedef struct packed {
      logic                 valid;
      ctx_type              ctx;
      logic [DEN_WIDTH-1:0] den;
      lane_type             t;
      lane_type             s;
   } cell_word_type;

endpackage

>>> rtl/core/llx_div_cell.sv
module llx_div_cell
   import llx_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  cell_word_type in_word,
   output cell_word_type out_word
);

   cell_word_type word_ff, word_in;

   // One restoring step: bring in the next numerator bit, subtract if it fits.
   function automatic lane_type step(input lane_type l, input logic [DEN_WIDTH-1:0] d);
      logic [DEN_WIDTH:0] rem2;
      logic               ge;
      lane_type           o;
      rem2  = {l.r, l.nlo[COORD_WIDTH-1]};
      ge    = rem2 >= {1'b0, d};
      o.r   = ge ? DEN_WIDTH'(rem2 - {1'b0, d}) : rem2[DEN_WIDTH-1:0];
      o.nlo = {l.nlo[COORD_WIDTH-2:0], 1'b0};
      o.q   = {l.q[COORD_WIDTH-2:0], ge};
      return o;
   endfunction

   always_comb begin
      word_in   = in_word;
      word_in.t = step(in_word.t, in_word.den);
      word_in.s = step(in_word.s, in_word.den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_word = word_ff;

endmodule

>>> rtl/core/llx_front.sv
module llx_front
   import llx_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  req_word_type  in_word,
   output cell_word_type out_word
);

   // stage A: unpack, origin difference
   logic                  a_valid_ff;
   coord_type [2:0]       a_ad_ff, a_bd_ff;
   delta_type [2:0]       a_v_ff;
   // stage B: products
   logic                  b_valid_ff;
   coord_type [2:0]       b_ad_ff, b_bd_ff;
   delta_type [2:0]       b_v_ff;
   logic signed [DEN_WIDTH-1:0] b_pd_ff [2][2];
   logic signed [NUM_WIDTH-3:0] b_pt_ff [2][2];
   logic signed [NUM_WIDTH-3:0] b_ps_ff [2][2];
   // stage C: determinant and numerators of the chosen pair
   logic                  c_valid_ff;
   coord_type [2:0]       c_ad_ff, c_bd_ff;
   delta_type [2:0]       c_v_ff;
   logic signed [DEN_WIDTH:0]   c_det_ff;
   logic signed [NUM_WIDTH-1:0] c_numt_ff, c_nums_ff;
   logic                  c_sing_ff;
   // stage D: magnitudes and signs
   logic                  d_valid_ff;
   coord_type [2:0]       d_ad_ff, d_bd_ff;
   delta_type [2:0]       d_v_ff;
   logic [DEN_WIDTH-1:0]  d_den_ff;
   logic [NUM_WIDTH-1:0]  d_nt_ff, d_ns_ff;
   logic                  d_sing_ff, d_tneg_ff, d_sneg_ff;
   // stage E: divider seed
   cell_word_type         e_word_ff, e_word_in;

   coord_type [2:0] ao, ad, bo, bd;
   logic signed [DEN_WIDTH:0]   det0, det1;
   logic signed [NUM_WIDTH-1:0] nt0, nt1, ns0, ns1;
   logic [NUM_WIDTH-1:0]        hi_t, hi_s;

   always_comb begin
      ao = {in_word.a_origin_z, in_word.a_origin_y, in_word.a_origin_x};
      ad = {in_word.a_dir_z, in_word.a_dir_y, in_word.a_dir_x};
      bo = {in_word.b_origin_z, in_word.b_origin_y, in_word.b_origin_x};
      bd = {in_word.b_dir_z, in_word.b_dir_y, in_word.b_dir_x};
   end

   always_comb begin
      det0 = $signed(b_pd_ff[0][0]) - $signed(b_pd_ff[0][1]);
      det1 = $signed(b_pd_ff[1][0]) - $signed(b_pd_ff[1][1]);
      nt0  = $signed(b_pt_ff[0][0]) - $signed(b_pt_ff[0][1]);
      nt1  = $signed(b_pt_ff[1][0]) - $signed(b_pt_ff[1][1]);
      ns0  = $signed(b_ps_ff[0][0]) - $signed(b_ps_ff[0][1]);
      ns1  = $signed(b_ps_ff[1][0]) - $signed(b_ps_ff[1][1]);
   end

   always_comb begin
      hi_t = d_nt_ff >> (COORD_WIDTH - FRAC_BITS);
      hi_s = d_ns_ff >> (COORD_WIDTH - FRAC_BITS);
      e_word_in.valid        = d_valid_ff;
      e_word_in.ctx.ad       = d_ad_ff;
      e_word_in.ctx.bd       = d_bd_ff;
      e_word_in.ctx.v        = d_v_ff;
      e_word_in.ctx.singular = d_sing_ff;
      e_word_in.ctx.t_neg    = d_tneg_ff;
      e_word_in.ctx.s_neg    = d_sneg_ff;
      // quotient needs more than COORD_WIDTH bits
      e_word_in.ctx.t_ovf    = hi_t >= NUM_WIDTH'(d_den_ff);
      e_word_in.ctx.s_ovf    = hi_s >= NUM_WIDTH'(d_den_ff);
      e_word_in.den          = d_den_ff;
      e_word_in.t.r          = hi_t[DEN_WIDTH-1:0];
      e_word_in.s.r          = hi_s[DEN_WIDTH-1:0];
      e_word_in.t.nlo        = COORD_WIDTH'(d_nt_ff << FRAC_BITS);
      e_word_in.s.nlo        = COORD_WIDTH'(d_ns_ff << FRAC_BITS);
      e_word_in.t.q          = '0;
      e_word_in.s.q          = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff      <= 1'b0;
         b_valid_ff      <= 1'b0;
         c_valid_ff      <= 1'b0;
         d_valid_ff      <= 1'b0;
         e_word_ff.valid <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         a_ad_ff    <= ad;
         a_bd_ff    <= bd;
         for (int k = 0; k < 3; k++) begin
            a_v_ff[k] <= DELTA_WIDTH'($signed(bo[k]) - $signed(ao[k]));
         end

         b_valid_ff <= a_valid_ff;
         b_ad_ff    <= a_ad_ff;
         b_bd_ff    <= a_bd_ff;
         b_v_ff     <= a_v_ff;
         for (int p = 0; p < 2; p++) begin
            b_pd_ff[p][0] <= $signed(a_ad_ff[p]) * $signed(a_bd_ff[p+1]);
            b_pd_ff[p][1] <= $signed(a_ad_ff[p+1]) * $signed(a_bd_ff[p]);
            b_pt_ff[p][0] <= $signed(a_bd_ff[p+1]) * $signed(a_v_ff[p]);
            b_pt_ff[p][1] <= $signed(a_bd_ff[p]) * $signed(a_v_ff[p+1]);
            b_ps_ff[p][0] <= $signed(a_ad_ff[p+1]) * $signed(a_v_ff[p]);
            b_ps_ff[p][1] <= $signed(a_ad_ff[p]) * $signed(a_v_ff[p+1]);
         end

         c_valid_ff <= b_valid_ff;
         c_ad_ff    <= b_ad_ff;
         c_bd_ff    <= b_bd_ff;
         c_v_ff     <= b_v_ff;
         c_sing_ff  <= (det0 == '0) && (det1 == '0);
         c_det_ff   <= (det0 != '0) ? det0 : det1;
         c_numt_ff  <= (det0 != '0) ? nt0 : nt1;
         c_nums_ff  <= (det0 != '0) ? ns0 : ns1;

         d_valid_ff <= c_valid_ff;
         d_ad_ff    <= c_ad_ff;
         d_bd_ff    <= c_bd_ff;
         d_v_ff     <= c_v_ff;
         d_sing_ff  <= c_sing_ff;
         d_den_ff   <= DEN_WIDTH'(c_det_ff[DEN_WIDTH] ? -c_det_ff : c_det_ff);
         d_nt_ff    <= c_numt_ff[NUM_WIDTH-1] ? NUM_WIDTH'(-c_numt_ff) : c_numt_ff;
         d_ns_ff    <= c_nums_ff[NUM_WIDTH-1] ? NUM_WIDTH'(-c_nums_ff) : c_nums_ff;
         d_tneg_ff  <= c_numt_ff[NUM_WIDTH-1] ^ c_det_ff[DEN_WIDTH];
         d_sneg_ff  <= c_nums_ff[NUM_WIDTH-1] ^ c_det_ff[DEN_WIDTH];

         e_word_ff  <= e_word_in;
      end
   end

   assign out_word = e_word_ff;

endmodule

>>> rtl/core/llx_back.sv
module llx_back
   import llx_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  cell_word_type in_word,
   input  logic [31:0]   tol,
   output logic          out_valid,
   output rsp_word_type  out_word
);

   localparam logic [COORD_WIDTH-1:0] NEG_LIM = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam logic [COORD_WIDTH-1:0] POS_LIM = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam int D_WIDTH = 2 * COORD_WIDTH + 2;

   // stage P: saturated quotients
   logic            p_valid_ff, p_sing_ff, p_clip_ff;
   coord_type       p_t_ff, p_s_ff;
   coord_type [2:0] p_ad_ff, p_bd_ff;
   delta_type [2:0] p_v_ff;
   // stage Q: products along both lines
   logic            q_valid_ff, q_sing_ff, q_clip_ff;
   coord_type       q_t_ff;
   delta_type [2:0] q_v_ff;
   logic signed [DEN_WIDTH-1:0] q_at_ff [3];
   logic signed [DEN_WIDTH-1:0] q_bs_ff [3];
   // stage R: gap per axis
   logic            r_valid_ff, r_sing_ff, r_clip_ff;
   coord_type       r_t_ff;
   logic signed [D_WIDTH-1:0] r_d_ff [3];
   // stage S: truncated magnitude
   logic            s_valid_ff, s_sing_ff, s_clip_ff, s_big_ff;
   coord_type       s_t_ff;
   logic [15:0]     s_m_ff [3];
   // stage T: squares
   logic            t_valid_ff, t_sing_ff, t_clip_ff, t_big_ff;
   coord_type       t_t_ff;
   logic [31:0]     t_sq_ff [3];
   // stage U: result
   logic            u_valid_ff;
   rsp_word_type    u_word_ff, u_word_in;

   logic            clip_t, clip_s;
   logic [COORD_WIDTH-1:0] mag_t, mag_s;
   logic [D_WIDTH-1:0]     dmag [3];
   logic [D_WIDTH-1:0]     m_full [3];
   logic [3:0]             big_k;
   logic [33:0]            sum;

   always_comb begin
      clip_t = in_word.ctx.t_ovf ||
               (in_word.ctx.t_neg ? (in_word.t.q > NEG_LIM) : (in_word.t.q > POS_LIM));
      clip_s = in_word.ctx.s_ovf ||
               (in_word.ctx.s_neg ? (in_word.s.q > NEG_LIM) : (in_word.s.q > POS_LIM));
      mag_t  = clip_t ? (in_word.ctx.t_neg ? NEG_LIM : POS_LIM) : in_word.t.q;
      mag_s  = clip_s ? (in_word.ctx.s_neg ? NEG_LIM : POS_LIM) : in_word.s.q;
   end

   always_comb begin
      big_k[3] = 1'b0;
      for (int k = 0; k < 3; k++) begin
         dmag[k]   = r_d_ff[k][D_WIDTH-1] ? D_WIDTH'(-r_d_ff[k]) : D_WIDTH'(r_d_ff[k]);
         m_full[k] = dmag[k] >> FRAC_BITS;
         big_k[k]  = m_full[k] >= D_WIDTH'(65536);
      end
      sum = 34'(t_sq_ff[0]) + 34'(t_sq_ff[1]) + 34'(t_sq_ff[2]);
   end

   always_comb begin
      u_word_in.clipped = t_clip_ff;
      if (t_sing_ff) begin
         u_word_in.line_param = '0;
         u_word_in.status     = STATUS_SINGULAR;
         u_word_in.clipped    = 1'b0;
      end else if (t_big_ff || (sum > 34'(tol))) begin
         u_word_in.line_param = '0;
         u_word_in.status     = STATUS_MISS;
      end else begin
         u_word_in.line_param = t_t_ff;
         u_word_in.status     = STATUS_HIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         q_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         t_valid_ff <= 1'b0;
         u_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= in_word.valid;
         p_sing_ff  <= in_word.ctx.singular;
         p_clip_ff  <= clip_t || clip_s;
         p_t_ff     <= in_word.ctx.t_neg ? coord_type'(-mag_t) : coord_type'(mag_t);
         p_s_ff     <= in_word.ctx.s_neg ? coord_type'(-mag_s) : coord_type'(mag_s);
         p_ad_ff    <= in_word.ctx.ad;
         p_bd_ff    <= in_word.ctx.bd;
         p_v_ff     <= in_word.ctx.v;

         q_valid_ff <= p_valid_ff;
         q_sing_ff  <= p_sing_ff;
         q_clip_ff  <= p_clip_ff;
         q_t_ff     <= p_t_ff;
         q_v_ff     <= p_v_ff;
         for (int k = 0; k < 3; k++) begin
            q_at_ff[k] <= $signed(p_ad_ff[k]) * $signed(p_t_ff);
            q_bs_ff[k] <= $signed(p_bd_ff[k]) * $signed(p_s_ff);
         end

         r_valid_ff <= q_valid_ff;
         r_sing_ff  <= q_sing_ff;
         r_clip_ff  <= q_clip_ff;
         r_t_ff     <= q_t_ff;
         for (int k = 0; k < 3; k++) begin
            r_d_ff[k] <= D_WIDTH'($signed(q_at_ff[k])) - D_WIDTH'($signed(q_bs_ff[k]))
                       - (D_WIDTH'($signed(q_v_ff[k])) <<< FRAC_BITS);
         end

         s_valid_ff <= r_valid_ff;
         s_sing_ff  <= r_sing_ff;
         s_clip_ff  <= r_clip_ff;
         s_t_ff     <= r_t_ff;
         s_big_ff   <= |big_k;
         for (int k = 0; k < 3; k++) begin
            s_m_ff[k] <= m_full[k][15:0];
         end

         t_valid_ff <= s_valid_ff;
         t_sing_ff  <= s_sing_ff;
         t_clip_ff  <= s_clip_ff;
         t_t_ff     <= s_t_ff;
         t_big_ff   <= s_big_ff;
         for (int k = 0; k < 3; k++) begin
            t_sq_ff[k] <= s_m_ff[k] * s_m_ff[k];
         end

         u_valid_ff <= t_valid_ff;
         u_word_ff  <= u_word_in;
      end
   end

   assign out_valid = u_valid_ff;
   assign out_word  = u_word_ff;

endmodule

>>> rtl/core/line_line_intersection_3d_unit.sv
// channel   direction  handshake                 word
// req       in         req_valid / req_ready     req_word (two lines, Q16.16)
// rsp       out        rsp_valid / rsp_ready     rsp_word (line_param, status, clipped)
// csr       in         csr_write_enable          csr_write_data (tolerance, Q0.32)
//
// One word enters per cycle while rsp is not stalled; 43 register stages lie between
// req and rsp. The divider is a chain of 32 cells, one quotient bit per cell,
// run for t and s side by side, between 5 setup and 6 distance-check stages.
// Reset (synchronous) empties the pipeline and sets the tolerance to 1.
// A stalled rsp freezes every stage at once; req_ready drops only while rsp is full
// and not being taken.
module line_line_intersection_3d_unit
   import llx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word,
   input  logic         csr_write_enable,
   input  logic [31:0]  csr_write_data
);

   logic          en;
   logic [31:0]   tol_ff;
   cell_word_type chain [DIV_CELLS+1];

   // Advance the whole pipe whenever the output slot is free or being drained.
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= 32'd1;
      end else if (csr_write_enable) begin
         tol_ff <= csr_write_data;
      end
   end

   // Determinants, numerators, magnitudes and divider seed.
   llx_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .in_word  (req_word),
      .out_word (chain[0])
   );

   // Restoring divider: each cell resolves one quotient bit and hands on.
   for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
      llx_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_word  (chain[i]),
         .out_word (chain[i+1])
      );
   end

   // Saturate, rebuild both points and check the squared gap.
   llx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_word   (chain[DIV_CELLS]),
      .tol       (tol_ff),
      .out_valid (rsp_valid),
      .out_word  (rsp_word)
   );

endmodule
